// ----- src/dpdr_pkg.sv -----
// Shared types, codes and constants for the dirty-pixel display refresh block.
`timescale 1ns / 1ps

package dpdr_pkg;

  // Screen and buffer geometry
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int MEMORY_BYTES  = 256;
  localparam int MEM_AW        = $clog2(MEMORY_BYTES);
  localparam int CELL_AW       = 8;   // three column bits, five row bits

  // Frame buffer: 320 bytes a row, each pixel a 4x6 block, origin at x 32, row 4
  localparam logic [15:0] ROW_BYTES     = 16'd320;
  localparam logic [15:0] TARGET_ORIGIN = 16'd32 + 16'd4 * ROW_BYTES;

  // Command codes
  localparam logic [1:0] CMD_WRITE      = 2'd0;
  localparam logic [1:0] CMD_REFRESH    = 2'd1;
  localparam logic [1:0] CMD_INVALIDATE = 2'd2;

  // Configuration register indexes
  localparam int          CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd1;

  // Shared adder operations
  localparam logic [1:0] OP_ADDR  = 2'd0;  // {row,col} + scroll
  localparam logic [1:0] OP_BASE1 = 2'd1;  // row*2048 - row*128
  localparam logic [1:0] OP_BASE2 = 2'd2;  // acc + col*32
  localparam logic [1:0] OP_BASE3 = 2'd3;  // acc + origin

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] mem_address;
    logic [7:0] mem_data;
    logic [2:0] cell_column;
    logic [4:0] pixel_row;
    logic [7:0] scroll_offset;
  } in_item_t;

  typedef struct packed {
    logic        changed;
    logic [5:0]  pixel_x;
    logic [4:0]  pixel_y;
    logic        pixel_on;
    logic [15:0] target_address;
    logic [31:0] colour_word;
    logic        last;
  } out_item_t;

  // Spread one colour byte over four bytes
  function automatic logic [31:0] replicate(input logic [7:0] v);
    return {v, v, v, v};
  endfunction

endpackage

// ----- src/dpdr_alu.sv -----
// Shared 16-bit add/subtract unit for address and target-base computation.
`timescale 1ns / 1ps

module dpdr_alu import dpdr_pkg::*; (
  input  logic [1:0]  op,
  input  logic [4:0]  row,
  input  logic [2:0]  col,
  input  logic [7:0]  scroll,
  input  logic [15:0] acc,
  output logic [15:0] result
);

  logic [15:0] opa;
  logic [15:0] opb;
  logic        sub;

  // Select operands for the current step
  always_comb begin
    opa = 16'd0;
    opb = 16'd0;
    sub = 1'b0;
    case (op)
      OP_ADDR: begin
        opa = {8'd0, row, col};
        opb = {8'd0, scroll};
      end
      OP_BASE1: begin
        opa = {row, 11'd0};
        opb = {4'd0, row, 7'd0};
        sub = 1'b1;
      end
      OP_BASE2: begin
        opa = acc;
        opb = {8'd0, col, 5'd0};
      end
      OP_BASE3: begin
        opa = acc;
        opb = TARGET_ORIGIN;
      end
      default: begin
        opa = 16'd0;
        opb = 16'd0;
      end
    endcase
  end

  assign result = sub ? (opa - opb) : (opa + opb);

endmodule

// ----- src/dirty_pixel_display_refresh_top.sv -----
// Top level: display memory, per-cell shadow, refresh sequencer and result register.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------
//  in_      | input     | in_valid / in_ready    | in_item  (in_item_t)
//  out_     | output    | out_valid / out_ready  | out_item (out_item_t)
//  cfg_     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Write and invalidate complete on acceptance. A refresh runs setup steps on the
// shared adder (display address, then three steps of the target base), then steps
// through the pixel positions up to the last changed pixel (at most 8), emitting
// an item for each changed one, or one empty closing item when nothing changed.
// Reset (synchronous, rst_n low) clears the display and shadow valid bits
// and loads the colour registers; no clearing pass follows.
// A stalled result register holds the sequencer in its emit state; the input is
// taken only when the sequencer is idle, and configuration is always taken.

module dirty_pixel_display_refresh_top import dpdr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADDR  = 3'd1;
  localparam logic [2:0] ST_BASE1 = 3'd2;
  localparam logic [2:0] ST_BASE2 = 3'd3;
  localparam logic [2:0] ST_BASE3 = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  // Storage
  logic [7:0]              disp_mem [MEMORY_BYTES];
  logic [7:0]              shadow_mem [2**CELL_AW];
  logic [MEMORY_BYTES-1:0] disp_vld_r;
  logic [2**CELL_AW-1:0]   row_vld_r;

  // Control and working registers
  logic [2:0]  state_r, state_nxt;
  logic [2:0]  col_r;
  logic [4:0]  row_r;
  logic [7:0]  scroll_r;
  logic [15:0] acc_r;
  logic [7:0]  disp_rd_r;
  logic        disp_vld_rd_r;
  logic [7:0]  shadow_rd_r;
  logic [7:0]  on_r;
  logic [7:0]  mask_r, mask_nxt;
  logic [2:0]  pix_r, pix_nxt;
  logic [7:0]  fg_r;
  logic [7:0]  bg_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  logic [1:0]  alu_op;
  logic [15:0] alu_res;
  logic        in_fire;
  logic        out_free;
  logic        emit_load;
  logic [7:0]  byte_px;
  logic [7:0]  vis_mask;
  logic        row_on;
  logic [7:0]  diff;
  logic [7:0]  mask_left;
  logic [CELL_AW-1:0] cell_idx;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cell_idx  = {col_r, row_r};

  // Shared adder step for the current state
  always_comb begin
    case (state_r)
      ST_ADDR:  alu_op = OP_ADDR;
      ST_BASE1: alu_op = OP_BASE1;
      ST_BASE2: alu_op = OP_BASE2;
      ST_BASE3: alu_op = OP_BASE3;
      default:  alu_op = OP_ADDR;
    endcase
  end

  dpdr_alu u_alu (
    .op     (alu_op),
    .row    (row_r),
    .col    (col_r),
    .scroll (scroll_r),
    .acc    (acc_r),
    .result (alu_res)
  );

  // Pixel-order view of the cell: pixel 0 is the byte's msb
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      byte_px[i]  = disp_vld_rd_r & disp_rd_r[7-i];
      vis_mask[i] = ({1'b0, col_r, 3'(i)} < 7'(SCREEN_WIDTH));
    end
    row_on = ({1'b0, row_r} < 6'(SCREEN_HEIGHT));
    diff   = row_vld_r[cell_idx] ? (byte_px ^ shadow_rd_r) : 8'hFF;
  end

  // Display memory: write on command, registered read during address step
  always_ff @(posedge clk) begin
    if (in_fire && in_item.command == CMD_WRITE) begin
      disp_mem[in_item.mem_address] <= in_item.mem_data;
    end
    if (state_r == ST_ADDR) begin
      disp_rd_r <= disp_mem[alu_res[MEM_AW-1:0]];
    end
  end

  // Shadow memory: one row of eight pixels per cell
  always_ff @(posedge clk) begin
    if (state_r == ST_ADDR) begin
      shadow_rd_r <= shadow_mem[cell_idx];
    end
    if (state_r == ST_BASE1) begin
      shadow_mem[cell_idx] <= byte_px;
    end
  end

  // Valid bits for display bytes and shadow cells
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_vld_r <= '0;
      row_vld_r  <= '0;
    end else begin
      if (in_fire && in_item.command == CMD_WRITE) begin
        disp_vld_r[in_item.mem_address] <= 1'b1;
      end
      if (in_fire && in_item.command == CMD_INVALIDATE) begin
        row_vld_r <= '0;
      end else if (state_r == ST_BASE1 && row_on) begin
        row_vld_r[cell_idx] <= 1'b1;
      end
    end
  end

  // Colour registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= 8'd15;
      bg_r <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FOREGROUND: fg_r <= cfg_data;
        REG_BACKGROUND: bg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and result selection
  always_comb begin
    state_nxt     = state_r;
    mask_nxt      = mask_r;
    pix_nxt       = pix_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    emit_load     = 1'b0;
    mask_left     = mask_r;
    mask_left[pix_r] = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_item.command == CMD_REFRESH) begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR:  state_nxt = ST_BASE1;
      ST_BASE1: begin
        mask_nxt  = diff & vis_mask & {8{row_on}};
        state_nxt = ST_BASE2;
      end
      ST_BASE2: state_nxt = ST_BASE3;
      ST_BASE3: begin
        pix_nxt   = 3'd0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (mask_r == 8'd0) begin
          // Nothing changed: one empty closing item
          if (out_free) begin
            emit_load    = 1'b1;
            out_item_nxt = '0;
            out_item_nxt.last = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else if (mask_r[pix_r]) begin
          if (out_free) begin
            emit_load                   = 1'b1;
            out_item_nxt.changed        = 1'b1;
            out_item_nxt.pixel_x        = {col_r, pix_r};
            out_item_nxt.pixel_y        = row_r;
            out_item_nxt.pixel_on       = on_r[pix_r];
            out_item_nxt.target_address = {acc_r[15:5], pix_r, 2'b00};
            out_item_nxt.colour_word    = replicate(on_r[pix_r] ? fg_r : bg_r);
            out_item_nxt.last           = (mask_left == 8'd0);
            mask_nxt                    = mask_left;
            pix_nxt                     = pix_r + 3'd1;
            if (mask_left == 8'd0) begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          // Skip an unchanged pixel
          pix_nxt = pix_r + 3'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (emit_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      col_r    <= in_item.cell_column;
      row_r    <= in_item.pixel_row;
      scroll_r <= in_item.scroll_offset;
    end
    if (state_r == ST_ADDR) begin
      disp_vld_rd_r <= disp_vld_r[alu_res[MEM_AW-1:0]];
    end
    if (state_r == ST_BASE1) begin
      on_r <= byte_px;
    end
    if (state_r == ST_BASE1 || state_r == ST_BASE2 || state_r == ST_BASE3) begin
      acc_r <= alu_res;
    end
    mask_r     <= mask_nxt;
    pix_r      <= pix_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule
